### rtl/timed_register_write_queue_defines.svh
// assertion macros for the timed register write queue
`ifndef TIMED_REGISTER_WRITE_QUEUE_DEFINES_SVH
`define TIMED_REGISTER_WRITE_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define TWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TWQ_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define TWQ_ASSERT(lbl, prop, msg)
`define TWQ_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

### rtl/twq_pkg.sv
package twq_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH   = 256;
  localparam int IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W         = IDX_W + 1;

  // entries sent per tick
  localparam int BATCH_BYTES   = 64;
  localparam int BATCH_ENTRIES = BATCH_BYTES / 4;
  localparam int SENT_W        = $clog2(BATCH_ENTRIES + 1);

  // field widths
  localparam int KIND_W  = 2;
  localparam int BUS_W   = 4;
  localparam int ADDR_W  = 9;
  localparam int DATA_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int DELAY_W = 14;
  localparam int TIME_W  = 32;

  localparam logic [DELAY_W-1:0] DELAY_LIMIT = 14'd10000;
  localparam logic [BYTE_W-1:0]  RESET_BYTE  = 8'hFE;
  localparam logic [BYTE_W-1:0]  DROP_BYTE   = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_RESET = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BYTE_BUS  = 2'd0,
    BYTE_PORT = 2'd1,
    BYTE_ADDR = 2'd2,
    BYTE_DATA = 2'd3
  } byte_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEND,
    ST_EMIT
  } state_e;

  // packed command word: bus, address bit 8, address low byte, data
  typedef struct packed {
    logic [BUS_W-1:0]  bus;
    logic              addr_hi;
    logic [7:0]        addr_lo;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    cmd_t              cmd;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### rtl/twq_intf.sv
interface twq_item_if;
  logic                          valid;
  logic                          ready;
  logic [twq_pkg::KIND_W-1:0]    kind;
  logic [twq_pkg::BUS_W-1:0]     bus_id;
  logic [twq_pkg::ADDR_W-1:0]    reg_addr;
  logic [twq_pkg::DATA_W-1:0]    reg_data;

  modport source (output valid, kind, bus_id, reg_addr, reg_data, input ready);
  modport sink   (input valid, kind, bus_id, reg_addr, reg_data, output ready);
endinterface

interface twq_result_if;
  logic                          valid;
  logic                          ready;
  logic [twq_pkg::BYTE_W-1:0]    out_byte;
  logic                          last_byte;
  logic                          dropped;

  modport source (output valid, out_byte, last_byte, dropped, input ready);
  modport sink   (input valid, out_byte, last_byte, dropped, output ready);
endinterface

### rtl/timed_register_write_queue.sv
// Timed register write queue. Register writes (kind write) are packed into a four-byte
// command and stored in a circular queue with a due time of now plus delay_ms; when the
// queue is full the write is refused and one beat with dropped set is returned. Each tick
// advances the millisecond counter, then sends due entries oldest first, at most
// BATCH_BYTES/4 per tick, each as four beats (bus id, port flag, address, data); last_byte
// marks the final beat caused by an item. A reset item empties the queue and returns the
// 0xFE beat unless no write came since the previous reset. Writes that are not refused are
// taken back to back. The entry memory has a registered read port, and output beats go out
// one per cycle while the output slot is free. The entry memory needs no clearing pass
// after reset: only written entries are ever read. The input is taken only while the
// block is idle; a pending output beat does not hold off writes.
`include "timed_register_write_queue_defines.svh"

module timed_register_write_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twq_pkg::DELAY_W-1:0]   cfg_wdata_i,
  twq_item_if.sink                      item_i,
  twq_result_if.source                  result_o
);

  // control state
  twq_pkg::state_e                 state_q, state_d;
  logic [twq_pkg::IDX_W-1:0]       head_q, head_d;
  logic [twq_pkg::CNT_W-1:0]       count_q, count_d;
  logic [twq_pkg::SENT_W-1:0]      sent_q, sent_d;
  logic [1:0]                      byte_idx_q, byte_idx_d;
  logic                            reset_done_q, reset_done_d;
  logic [twq_pkg::TIME_W-1:0]      now_q, now_d;
  logic [twq_pkg::DELAY_W-1:0]     delay_q;

  // command being sent and the pending single-beat result
  twq_pkg::cmd_t                   cmd_q, cmd_d;
  logic [twq_pkg::BYTE_W-1:0]      pend_byte_q, pend_byte_d;
  logic                            pend_drop_q, pend_drop_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [twq_pkg::BYTE_W-1:0]      out_byte_q, out_byte_d;
  logic                            out_last_q, out_last_d;
  logic                            out_drop_q, out_drop_d;

  // memory port
  logic                            ram_we;
  logic [twq_pkg::IDX_W-1:0]       ram_waddr;
  twq_pkg::entry_t                 ram_wdata;
  twq_pkg::entry_t                 ram_rdata;

  logic                            item_acc;
  twq_pkg::kind_e                  kind;
  logic                            full;
  logic [twq_pkg::SUM_W-1:0]       tail_sum;
  logic [twq_pkg::IDX_W-1:0]       tail_idx;
  logic [twq_pkg::IDX_W-1:0]       head_next;
  logic [twq_pkg::TIME_W-1:0]      due_diff;
  logic                            head_due;
  logic                            more;
  logic                            slot_free;
  logic [twq_pkg::BYTE_W-1:0]      cur_byte;

  assign item_acc  = item_i.valid && item_i.ready;
  assign kind      = twq_pkg::kind_e'(item_i.kind);
  assign full      = (count_q == twq_pkg::CNT_W'(twq_pkg::QUEUE_DEPTH));
  assign slot_free = !out_valid_q || result_o.ready;

  // tail slot, (head + count) mod depth; the sum stays below twice the depth
  assign tail_sum = twq_pkg::SUM_W'(head_q) + twq_pkg::SUM_W'(count_q);
  assign tail_idx = (tail_sum >= twq_pkg::SUM_W'(twq_pkg::QUEUE_DEPTH))
                  ? twq_pkg::IDX_W'(tail_sum - twq_pkg::SUM_W'(twq_pkg::QUEUE_DEPTH))
                  : twq_pkg::IDX_W'(tail_sum);
  assign head_next = (head_q == twq_pkg::IDX_W'(twq_pkg::QUEUE_DEPTH - 1))
                   ? '0 : head_q + 1'b1;

  // due when the signed difference is zero or negative, works across the counter wrap
  assign due_diff = ram_rdata.due - now_q;
  assign head_due = (due_diff == '0) || due_diff[twq_pkg::TIME_W-1];

  // another entry follows in this tick; memory output holds the current head
  assign more = (count_q != '0) && (sent_q < twq_pkg::SENT_W'(twq_pkg::BATCH_ENTRIES))
             && head_due;

  // byte of the command being sent
  always_comb begin
    case (twq_pkg::byte_sel_e'(byte_idx_q))
      twq_pkg::BYTE_BUS:  cur_byte = twq_pkg::BYTE_W'(cmd_q.bus);
      twq_pkg::BYTE_PORT: cur_byte = {6'b0, cmd_q.addr_hi, 1'b0};
      twq_pkg::BYTE_ADDR: cur_byte = cmd_q.addr_lo;
      twq_pkg::BYTE_DATA: cur_byte = cmd_q.data;
      default:            cur_byte = '0;
    endcase
  end

  // memory: write at the tail, read the head every cycle
  assign ram_waddr     = tail_idx;
  assign ram_wdata.due = now_q + twq_pkg::TIME_W'(delay_q);
  assign ram_wdata.cmd = '{bus:     item_i.bus_id,
                           addr_hi: item_i.reg_addr[8],
                           addr_lo: item_i.reg_addr[7:0],
                           data:    item_i.reg_data};

  twq_ram #(
    .WIDTH (twq_pkg::ENTRY_W),
    .DEPTH (twq_pkg::QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // input is taken only in idle
  assign item_i.ready = (state_q == twq_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twq_pkg::ST_IDLE: begin
        if (item_acc) begin
          case (kind)
            twq_pkg::KIND_WRITE: state_d = full ? twq_pkg::ST_EMIT : twq_pkg::ST_IDLE;
            twq_pkg::KIND_TICK:  state_d = (count_q == '0) ? twq_pkg::ST_IDLE
                                                           : twq_pkg::ST_CHECK;
            twq_pkg::KIND_RESET: state_d = reset_done_q ? twq_pkg::ST_IDLE
                                                        : twq_pkg::ST_EMIT;
            default:             state_d = twq_pkg::ST_IDLE;
          endcase
        end
      end
      twq_pkg::ST_CHECK: begin
        state_d = head_due ? twq_pkg::ST_SEND : twq_pkg::ST_IDLE;
      end
      twq_pkg::ST_SEND: begin
        if (slot_free && byte_idx_q == 2'(twq_pkg::BYTE_DATA) && !more) begin
          state_d = twq_pkg::ST_IDLE;
        end
      end
      twq_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = twq_pkg::ST_IDLE;
        end
      end
      default: state_d = twq_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    sent_d       = sent_q;
    byte_idx_d   = byte_idx_q;
    reset_done_d = reset_done_q;
    now_d        = now_q;
    cmd_d        = cmd_q;
    pend_byte_d  = pend_byte_q;
    pend_drop_d  = pend_drop_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_drop_d   = out_drop_q;
    ram_we       = 1'b0;

    case (state_q)
      twq_pkg::ST_IDLE: begin
        if (item_acc) begin
          case (kind)
            twq_pkg::KIND_WRITE: begin
              reset_done_d = 1'b0;
              if (full) begin
                pend_byte_d = twq_pkg::DROP_BYTE;
                pend_drop_d = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            twq_pkg::KIND_TICK: begin
              now_d  = now_q + 1'b1;
              sent_d = '0;
            end
            twq_pkg::KIND_RESET: begin
              if (!reset_done_q) begin
                head_d       = '0;
                count_d      = '0;
                reset_done_d = 1'b1;
                pend_byte_d  = twq_pkg::RESET_BYTE;
                pend_drop_d  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      twq_pkg::ST_CHECK: begin
        // first entry of the tick, pop it if due
        if (head_due) begin
          cmd_d      = ram_rdata.cmd;
          head_d     = head_next;
          count_d    = count_q - 1'b1;
          sent_d     = sent_q + 1'b1;
          byte_idx_d = '0;
        end
      end
      twq_pkg::ST_SEND: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = cur_byte;
          out_drop_d  = 1'b0;
          out_last_d  = 1'b0;
          if (byte_idx_q == 2'(twq_pkg::BYTE_DATA)) begin
            // memory has settled on the new head by now
            out_last_d = !more;
            if (more) begin
              cmd_d      = ram_rdata.cmd;
              head_d     = head_next;
              count_d    = count_q - 1'b1;
              sent_d     = sent_q + 1'b1;
              byte_idx_d = '0;
            end
          end else begin
            byte_idx_d = byte_idx_q + 1'b1;
          end
        end
      end
      twq_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = pend_byte_q;
          out_last_d  = 1'b1;
          out_drop_d  = pend_drop_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= twq_pkg::ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      sent_q       <= '0;
      byte_idx_q   <= '0;
      reset_done_q <= 1'b0;
      now_q        <= '0;
      delay_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      sent_q       <= sent_d;
      byte_idx_q   <= byte_idx_d;
      reset_done_q <= reset_done_d;
      now_q        <= now_d;
      out_valid_q  <= out_valid_d;
      // out-of-range delays are ignored
      if (cfg_we_i && cfg_wdata_i <= twq_pkg::DELAY_LIMIT) begin
        delay_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    pend_byte_q <= pend_byte_d;
    pend_drop_q <= pend_drop_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_drop_q  <= out_drop_d;
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.out_byte  = out_byte_q;
  assign result_o.last_byte = out_last_q;
  assign result_o.dropped   = out_drop_q;

  // checks
  `TWQ_ASSERT(a_count_bound, count_q <= twq_pkg::CNT_W'(twq_pkg::QUEUE_DEPTH), "queue overfilled")
  `TWQ_ASSERT(a_batch_bound, sent_q <= twq_pkg::SENT_W'(twq_pkg::BATCH_ENTRIES), "batch overrun")
  `TWQ_ASSERT(a_write_count, ram_we |=> count_q == $past(count_q) + 1'b1, "write not counted")
  `TWQ_ASSERT_NEVER(a_drop_send, out_valid_q && out_drop_q && !out_last_q, "drop beat not last")

endmodule

### rtl/twq_ram.sv
module twq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
